// ===== rtl/sosfg_pkg.sv =====
// Shared types and constants of the sum-of-sinusoids fading generator.
`default_nettype none

package sosfg_pkg;

    localparam int MAX_WAVES_DEFAULT      = 16;
    localparam int COS_TABLE_BITS_DEFAULT = 10;

    localparam int WEIGHT_W = 16;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 24;
    localparam int COS_W    = 15;
    localparam int MUL_W    = 24;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int CFG_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int PADDR_W  = 3;

    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic REG_WAVE_COUNT    = 1'b0;
    localparam logic REG_INITIAL_PHASE = 1'b1;

    typedef struct packed {
        logic [1:0]                 command;
        logic [3:0]                 wave_index;
        logic signed [WEIGHT_W-1:0] weight_real;
        logic signed [WEIGHT_W-1:0] weight_imag;
        logic [PHASE_W-1:0]         phase_step;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_real;
        logic signed [SAMPLE_W-1:0] sample_imag;
        logic [SAMPLE_W-1:0]        magnitude;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_PHASE,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_ACC_IM,
        ST_ROUND,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SQ_SUM,
        ST_ROOT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/sosfg_cos.sv =====
// Quarter-wave cosine table with quadrant folding and registered read.
`default_nettype none

module sosfg_cos #(
    parameter int COS_TABLE_BITS = sosfg_pkg::COS_TABLE_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [sosfg_pkg::PHASE_W-1:0]     phase,
    output logic signed [sosfg_pkg::WEIGHT_W-1:0]  cos_val
);

    localparam int TBL = 1 << COS_TABLE_BITS;

    typedef logic [sosfg_pkg::COS_W-1:0] rom_t [TBL];

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b,
                                              int unsigned s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p >> s);
    endfunction

    // Taylor series of cos in Q60, rounded to Q14
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k < TBL; k++)
        begin
            x    = mul_shift(sosfg_pkg::HALF_PI_Q60, 64'(k), COS_TABLE_BITS);
            x2   = mul_shift(x, x, 60);
            term = 64'd1 << 60;
            sum  = term;
            for (int n = 1; n <= 14; n++)
            begin
                term = mul_shift(term, x2, 60) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            r[k] = sosfg_pkg::COS_W'((sum + (64'd1 << 45)) >> 46);
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [1:0]                    quad;
    logic [COS_TABLE_BITS-1:0]     k;
    logic [COS_TABLE_BITS-1:0]     addr;
    logic [sosfg_pkg::COS_W-1:0]   rom_reg;
    logic                          zero_reg;
    logic                          neg_reg;

    assign quad = phase[sosfg_pkg::PHASE_W-1 -: 2];
    assign k    = phase[sosfg_pkg::PHASE_W-3 -: COS_TABLE_BITS];
    assign addr = quad[0] ? COS_TABLE_BITS'(-k) : k;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rom_reg  <= ROM[addr];
            zero_reg <= quad[0] && (k == '0);
            neg_reg  <= quad[1] ^ quad[0];
        end
    end

    always_comb
    begin
        if (zero_reg)
            cos_val = '0;
        else if (neg_reg)
            cos_val = -signed'({1'b0, rom_reg});
        else
            cos_val = signed'({1'b0, rom_reg});
    end

endmodule

`default_nettype wire

// ===== rtl/sum_of_sinusoids_fading_generator.sv =====
// Top level of the sum-of-sinusoids fading generator: sequencer, stores, shared multiplier.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------
//  item     | item_valid / item_ready       | sosfg_pkg::item_t
//  sample   | sample_valid / sample_ready   | sosfg_pkg::sample_t
//  apb      | psel penable pwrite pready    | paddr pwdata prdata
//
// Load and clear items are taken in ST_IDLE, which they do not leave. In a
// tick, one 24x24 multiplier is shared by both weight products and both squares,
// and the root is computed bit by bit in ST_ROOT.
// Reset clears all phase accumulators through per-entry valid bits.
// A finished sample waits in the output register while loads and clears go on; a later tick stalls in ST_OUT.
`default_nettype none

module sum_of_sinusoids_fading_generator #(
    parameter int MAX_WAVES      = sosfg_pkg::MAX_WAVES_DEFAULT,
    parameter int COS_TABLE_BITS = sosfg_pkg::COS_TABLE_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire sosfg_pkg::item_t                 item,
    output logic                                  sample_valid,
    input  wire logic                             sample_ready,
    output sosfg_pkg::sample_t                    sample,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sosfg_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [sosfg_pkg::CFG_W-1:0]      pwdata,
    output logic [sosfg_pkg::CFG_W-1:0]           prdata,
    output logic                                  pready
);

    localparam int AW     = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
    localparam int SW     = 32 + AW;
    localparam int CW     = (AW > sosfg_pkg::COUNT_W) ? AW : sosfg_pkg::COUNT_W;
    localparam int PW     = sosfg_pkg::PHASE_W;
    localparam int WW     = sosfg_pkg::WEIGHT_W;
    localparam int OW     = sosfg_pkg::SAMPLE_W;
    localparam int MW     = sosfg_pkg::MUL_W;
    localparam int QW     = sosfg_pkg::PROD_W;

    // configuration
    logic                                 cfg_we;
    logic [sosfg_pkg::COUNT_W-1:0]        wave_count_reg;
    logic [PW-1:0]                        initial_phase_reg;

    // sequencer
    sosfg_pkg::state_t                    state_reg;
    sosfg_pkg::state_t                    state_next;
    logic [AW-1:0]                        idx_reg;
    logic [AW-1:0]                        idx_next;
    logic                                 active;
    logic                                 last;
    logic                                 accept;
    logic                                 mem_re;
    logic                                 acc_we;
    logic                                 cos_en;
    logic                                 sample_load;

    // stores
    logic [2*WW-1:0]                      wgt_mem [MAX_WAVES];
    logic [PW-1:0]                        step_mem [MAX_WAVES];
    logic [PW-1:0]                        acc_mem [MAX_WAVES];
    logic [2*WW-1:0]                      wgt_q;
    logic [PW-1:0]                        step_q;
    logic [PW-1:0]                        acc_q;
    logic [MAX_WAVES-1:0]                 acc_valid_reg;
    logic [MAX_WAVES-1:0]                 acc_valid_next;
    logic                                 load_we;
    logic [AW-1:0]                        load_addr;
    logic [PW-1:0]                        acc_cur;
    logic [PW-1:0]                        acc_sum;
    logic [PW-1:0]                        phase_sum;
    logic signed [WW-1:0]                 cos_val;

    // datapath
    logic signed [MW-1:0]                 mul_a;
    logic signed [MW-1:0]                 mul_b;
    logic signed [QW-1:0]                 prod_reg;
    logic signed [QW-1:0]                 prod_next;
    logic signed [SW-1:0]                 sum_re_reg;
    logic signed [SW-1:0]                 sum_re_next;
    logic signed [SW-1:0]                 sum_im_reg;
    logic signed [SW-1:0]                 sum_im_next;
    logic signed [OW-1:0]                 re_reg;
    logic signed [OW-1:0]                 re_next;
    logic signed [OW-1:0]                 im_reg;
    logic signed [OW-1:0]                 im_next;
    logic [QW-1:0]                        rem_reg;
    logic [QW-1:0]                        rem_next;
    logic [QW-1:0]                        root_reg;
    logic [QW-1:0]                        root_next;
    logic [QW-1:0]                        bit_reg;
    logic [QW-1:0]                        bit_next;
    logic [QW-1:0]                        trial;
    logic                                 sample_valid_reg;
    sosfg_pkg::sample_t                   sample_reg;

    function automatic logic signed [OW-1:0] round_sat(logic signed [SW-1:0] s);
        logic signed [SW:0]  t;
        logic signed [63:0]  e;
        t = {s[SW-1], s} + (SW+1)'(1 << 13);
        e = 64'(t >>> 14);
        if (e > 64'sd8388607)
            return OW'(24'h7FFFFF);
        else if (e < -64'sd8388608)
            return OW'(24'h800000);
        else
            return OW'(e);
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_count_reg    <= sosfg_pkg::COUNT_W'(1);
            initial_phase_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (paddr[2])
                sosfg_pkg::REG_WAVE_COUNT:
                    wave_count_reg <= pwdata[sosfg_pkg::COUNT_W-1:0];
                sosfg_pkg::REG_INITIAL_PHASE:
                    initial_phase_reg <= pwdata;
                default:
                    initial_phase_reg <= initial_phase_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sosfg_pkg::REG_WAVE_COUNT:
                prdata = {{(sosfg_pkg::CFG_W - sosfg_pkg::COUNT_W){1'b0}}, wave_count_reg};
            sosfg_pkg::REG_INITIAL_PHASE:
                prdata = initial_phase_reg;
            default:
                prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign accept    = item_valid && item_ready;
    assign load_we   = accept && (item.command == sosfg_pkg::CMD_LOAD)
                       && (int'(item.wave_index) < MAX_WAVES);
    assign load_addr = AW'(item.wave_index);
    assign active    = CW'(idx_reg) < CW'(wave_count_reg);
    assign last      = idx_reg == AW'(MAX_WAVES - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sosfg_pkg::ST_IDLE:
                if (item_valid && item.command == sosfg_pkg::CMD_TICK)
                    state_next = sosfg_pkg::ST_READ;
            sosfg_pkg::ST_READ:
                state_next = sosfg_pkg::ST_PHASE;
            sosfg_pkg::ST_PHASE:
                if (active)
                    state_next = sosfg_pkg::ST_MUL_RE;
                else if (last)
                    state_next = sosfg_pkg::ST_ROUND;
                else
                    state_next = sosfg_pkg::ST_READ;
            sosfg_pkg::ST_MUL_RE:
                state_next = sosfg_pkg::ST_MUL_IM;
            sosfg_pkg::ST_MUL_IM:
                state_next = sosfg_pkg::ST_ACC_IM;
            sosfg_pkg::ST_ACC_IM:
                state_next = last ? sosfg_pkg::ST_ROUND : sosfg_pkg::ST_READ;
            sosfg_pkg::ST_ROUND:
                state_next = sosfg_pkg::ST_SQ_RE;
            sosfg_pkg::ST_SQ_RE:
                state_next = sosfg_pkg::ST_SQ_IM;
            sosfg_pkg::ST_SQ_IM:
                state_next = sosfg_pkg::ST_SQ_SUM;
            sosfg_pkg::ST_SQ_SUM:
                state_next = sosfg_pkg::ST_ROOT;
            sosfg_pkg::ST_ROOT:
                if (bit_reg[0])
                    state_next = sosfg_pkg::ST_OUT;
            sosfg_pkg::ST_OUT:
                if (!sample_valid_reg || sample_ready)
                    state_next = sosfg_pkg::ST_IDLE;
            default:
                state_next = sosfg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready  = 1'b0;
        mem_re      = 1'b0;
        acc_we      = 1'b0;
        cos_en      = 1'b0;
        sample_load = 1'b0;
        unique case (state_reg)
            sosfg_pkg::ST_IDLE:
                item_ready = 1'b1;
            sosfg_pkg::ST_READ:
                mem_re = 1'b1;
            sosfg_pkg::ST_PHASE:
            begin
                acc_we = 1'b1;
                cos_en = 1'b1;
            end
            sosfg_pkg::ST_OUT:
                sample_load = !sample_valid_reg || sample_ready;
            default:
                item_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
            idx_next = '0;
        else if ((state_reg == sosfg_pkg::ST_PHASE && !active && !last)
                 || (state_reg == sosfg_pkg::ST_ACC_IM && !last))
            idx_next = idx_reg + AW'(1);
    end

    // ---------------- stores ----------------
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            wgt_mem[load_addr]  <= {item.weight_real, item.weight_imag};
            step_mem[load_addr] <= item.phase_step;
        end
        if (acc_we)
            acc_mem[idx_reg] <= acc_sum;
        if (mem_re)
        begin
            wgt_q  <= wgt_mem[idx_reg];
            step_q <= step_mem[idx_reg];
            acc_q  <= acc_mem[idx_reg];
        end
    end

    always_comb
    begin
        acc_valid_next = acc_valid_reg;
        if (accept && item.command == sosfg_pkg::CMD_CLEAR)
            acc_valid_next = '0;
        if (load_we)
            acc_valid_next[load_addr] = 1'b0;
        if (acc_we)
            acc_valid_next[idx_reg] = 1'b1;
    end

    assign acc_cur   = acc_valid_reg[idx_reg] ? acc_q : '0;
    assign acc_sum   = acc_cur + step_q;
    assign phase_sum = acc_cur + initial_phase_reg;

    sosfg_cos #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_cos (
        .clk     (clk),
        .en      (cos_en),
        .phase   (phase_sum),
        .cos_val (cos_val)
    );

    // ---------------- datapath ----------------
    always_comb
    begin
        mul_a = re_reg;
        mul_b = re_reg;
        unique case (state_reg)
            sosfg_pkg::ST_MUL_RE:
            begin
                mul_a = MW'(signed'(wgt_q[2*WW-1:WW]));
                mul_b = MW'(cos_val);
            end
            sosfg_pkg::ST_MUL_IM:
            begin
                mul_a = MW'(signed'(wgt_q[WW-1:0]));
                mul_b = MW'(cos_val);
            end
            sosfg_pkg::ST_SQ_IM:
            begin
                mul_a = im_reg;
                mul_b = im_reg;
            end
            default:
            begin
                mul_a = re_reg;
                mul_b = re_reg;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign trial     = root_reg + bit_reg;

    always_comb
    begin
        sum_re_next = sum_re_reg;
        sum_im_next = sum_im_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        unique case (state_reg)
            sosfg_pkg::ST_IDLE:
            begin
                sum_re_next = '0;
                sum_im_next = '0;
            end
            sosfg_pkg::ST_MUL_IM:
                sum_re_next = sum_re_reg + SW'(prod_reg);
            sosfg_pkg::ST_ACC_IM:
                sum_im_next = sum_im_reg + SW'(prod_reg);
            sosfg_pkg::ST_ROUND:
            begin
                re_next = round_sat(sum_re_reg);
                im_next = round_sat(sum_im_reg);
            end
            sosfg_pkg::ST_SQ_IM:
                rem_next = prod_reg;
            sosfg_pkg::ST_SQ_SUM:
            begin
                rem_next  = rem_reg + prod_reg;
                root_next = '0;
                bit_next  = QW'(1) << (QW - 2);
            end
            sosfg_pkg::ST_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            default:
                bit_next = bit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        sum_re_reg <= sum_re_next;
        sum_im_reg <= sum_im_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        if (sample_load)
        begin
            sample_reg.sample_real <= re_reg;
            sample_reg.sample_imag <= im_reg;
            sample_reg.magnitude   <= root_reg[OW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sosfg_pkg::ST_IDLE;
            idx_reg          <= '0;
            acc_valid_reg    <= '0;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            acc_valid_reg <= acc_valid_next;
            if (sample_load)
                sample_valid_reg <= 1'b1;
            else if (sample_ready)
                sample_valid_reg <= 1'b0;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;

endmodule

`default_nettype wire

// ===== tb/fading_checker.sv =====
// Checker for the fading generator: tracks wave state, predicts tick samples, compares.
`default_nettype none

module fading_checker #(
    parameter int WAVES      = sosfg_pkg::MAX_WAVES_DEFAULT,
    parameter int TABLE_BITS = sosfg_pkg::COS_TABLE_BITS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    input  wire logic                           item_ready,
    input  wire sosfg_pkg::item_t               item,
    input  wire logic                           sample_valid,
    input  wire logic                           sample_ready,
    input  wire sosfg_pkg::sample_t             sample,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic                           pready,
    input  wire logic [sosfg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [sosfg_pkg::CFG_W-1:0]    pwdata,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  checked
);

    localparam int          TBL       = 1 << TABLE_BITS;
    localparam logic [63:0] PI_2_Q60  = 64'h1921FB54442D1846;
    localparam longint      SAMPLE_HI = 64'sd8388607;
    localparam longint      SAMPLE_LO = -64'sd8388608;

    logic [15:0]        cos_quarter [TBL];
    logic signed [15:0] wave_re     [WAVES];
    logic signed [15:0] wave_im     [WAVES];
    logic [31:0]        wave_step   [WAVES];
    logic [31:0]        wave_phase  [WAVES];
    logic [4:0]         cfg_wave_count;
    logic [31:0]        cfg_initial_phase;
    sosfg_pkg::sample_t expected_samples [$];
    sosfg_pkg::sample_t want;

    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // quarter-wave cosine in Q14, Taylor series in Q60
    initial
    begin
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] total;
        for (int k = 0; k < TBL; k++)
        begin
            x = mul_shr(PI_2_Q60, 64'(k), TABLE_BITS);
            x2 = mul_shr(x, x, 60);
            term = 64'd1 << 60;
            total = term;
            for (int n = 1; n <= 14; n++)
            begin
                term = mul_shr(term, x2, 60) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                    total = total - term;
                else
                    total = total + term;
            end
            cos_quarter[k] = 16'((total + (64'd1 << 45)) >> 46);
        end
    end

    function automatic int cos_q14(input logic [31:0] ph);
        logic [TABLE_BITS+1:0] idx;
        logic [1:0]            quad;
        int                    k;
        idx = ph[31 -: TABLE_BITS + 2];
        quad = idx[TABLE_BITS+1 -: 2];
        k = int'(idx[TABLE_BITS-1:0]);
        case (quad)
            2'd0: return int'(cos_quarter[k]);
            2'd1: return (k == 0) ? 0 : -int'(cos_quarter[TBL - k]);
            2'd2: return -int'(cos_quarter[k]);
            default: return (k == 0) ? 0 : int'(cos_quarter[TBL - k]);
        endcase
    endfunction

    // Q28 sum -> Q14, round half up, saturate to 24 bits
    function automatic longint q28_to_q14(input longint s);
        longint r;
        r = (s + 64'sd8192) >>> 14;
        if (r > SAMPLE_HI)
            r = SAMPLE_HI;
        else if (r < SAMPLE_LO)
            r = SAMPLE_LO;
        return r;
    endfunction

    function automatic logic [23:0] floor_root(input longint v);
        logic [23:0] root;
        longint      cand;
        root = '0;
        for (int b = 23; b >= 0; b--)
        begin
            cand = longint'(root) | (64'sd1 << b);
            if (cand * cand <= v)
                root = 24'(cand);
        end
        return root;
    endfunction

    // one fading sample from the current phases, then advance every wave
    function automatic sosfg_pkg::sample_t tick_sample();
        longint             sum_re;
        longint             sum_im;
        longint             re;
        longint             im;
        int                 active;
        int                 c;
        sosfg_pkg::sample_t s;
        active = (int'(cfg_wave_count) > WAVES) ? WAVES : int'(cfg_wave_count);
        sum_re = 0;
        sum_im = 0;
        for (int i = 0; i < active; i++)
        begin
            c = cos_q14(wave_phase[i] + cfg_initial_phase);
            sum_re += longint'(wave_re[i]) * longint'(c);
            sum_im += longint'(wave_im[i]) * longint'(c);
        end
        for (int i = 0; i < WAVES; i++)
            wave_phase[i] = wave_phase[i] + wave_step[i];
        re = q28_to_q14(sum_re);
        im = q28_to_q14(sum_im);
        s.sample_real = 24'(re);
        s.sample_imag = 24'(im);
        s.magnitude = floor_root(re * re + im * im);
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAVES; i++)
            begin
                wave_re[i] = '0;
                wave_im[i] = '0;
                wave_step[i] = '0;
                wave_phase[i] = '0;
            end
            cfg_wave_count = 5'd1;
            cfg_initial_phase = '0;
            expected_samples.delete();
            mismatches = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    $error("sample with none expected: real %0d imag %0d mag %0d",
                           sample.sample_real, sample.sample_imag, sample.magnitude);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    checked++;
                    if (sample.sample_real !== want.sample_real)
                    begin
                        mismatches++;
                        $error("sample_real: expected %0d, got %0d",
                               want.sample_real, sample.sample_real);
                    end
                    if (sample.sample_imag !== want.sample_imag)
                    begin
                        mismatches++;
                        $error("sample_imag: expected %0d, got %0d",
                               want.sample_imag, sample.sample_imag);
                    end
                    if (sample.magnitude !== want.magnitude)
                    begin
                        mismatches++;
                        $error("magnitude: expected %0d, got %0d",
                               want.magnitude, sample.magnitude);
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                case (item.command)
                    sosfg_pkg::CMD_LOAD:
                    begin
                        if (int'(item.wave_index) < WAVES)
                        begin
                            wave_re[item.wave_index] = item.weight_real;
                            wave_im[item.wave_index] = item.weight_imag;
                            wave_step[item.wave_index] = item.phase_step;
                            wave_phase[item.wave_index] = '0;
                        end
                    end
                    sosfg_pkg::CMD_TICK:
                        expected_samples.push_back(tick_sample());
                    sosfg_pkg::CMD_CLEAR:
                        for (int i = 0; i < WAVES; i++)
                            wave_phase[i] = '0;
                    default:
                        ;
                endcase
            end
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
            begin
                case (paddr[2])
                    sosfg_pkg::REG_WAVE_COUNT:
                        cfg_wave_count = pwdata[sosfg_pkg::COUNT_W-1:0];
                    sosfg_pkg::REG_INITIAL_PHASE:
                        cfg_initial_phase = pwdata;
                    default:
                        ;
                endcase
            end
            pending = expected_samples.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for the fading generator: clock, reset, stimulus, verdict.
`default_nettype none

module tb_top;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         SETTLE_CYCLES  = 150;

    logic                           clk;
    logic                           rst_n;
    logic                           item_valid   = 1'b0;
    logic                           item_ready;
    sosfg_pkg::item_t               item         = '0;
    logic                           sample_valid;
    logic                           sample_ready = 1'b0;
    sosfg_pkg::sample_t             sample;
    logic                           psel         = 1'b0;
    logic                           penable      = 1'b0;
    logic                           pwrite       = 1'b0;
    logic [sosfg_pkg::PADDR_W-1:0]  paddr        = '0;
    logic [sosfg_pkg::CFG_W-1:0]    pwdata       = '0;
    logic [sosfg_pkg::CFG_W-1:0]    prdata;
    logic                           pready;

    int mismatches;
    int pending;
    int checked;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int n_load = 0;
    int n_tick = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_settings = 0;

    sum_of_sinusoids_fading_generator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    fading_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        sample_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (sample_valid && sample_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic sosfg_pkg::item_t op_item(input logic [1:0] cmd);
        sosfg_pkg::item_t it;
        it.command = cmd;
        it.wave_index = 4'($urandom);
        it.weight_real = 16'($urandom);
        it.weight_imag = 16'($urandom);
        it.phase_step = $urandom;
        return it;
    endfunction

    function automatic sosfg_pkg::item_t load_item(input int w,
                                                   input logic signed [15:0] re,
                                                   input logic signed [15:0] im,
                                                   input logic [31:0] step);
        sosfg_pkg::item_t it;
        it.command = sosfg_pkg::CMD_LOAD;
        it.wave_index = 4'(w);
        it.weight_real = re;
        it.weight_imag = im;
        it.phase_step = step;
        return it;
    endfunction

    function automatic logic signed [15:0] random_weight();
        if ($urandom_range(99) >= 20)
            return 16'($urandom);
        case ($urandom_range(3))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return 16'sh0000;
            default: return -16'sh0001;
        endcase
    endfunction

    function automatic logic [31:0] random_step();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return $urandom_range(32'h0040_0000);
        if (pick < 60)
            return ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : 32'h4000_0000;
        return $urandom;
    endfunction

    function automatic sosfg_pkg::item_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return op_item(sosfg_pkg::CMD_TICK);
        if (pick < 85)
            return load_item($urandom_range(15), random_weight(), random_weight(),
                             random_step());
        if (pick < 95)
            return op_item(sosfg_pkg::CMD_CLEAR);
        return op_item(CMD_UNUSED);
    endfunction

    task automatic send_item(input sosfg_pkg::item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (!item_ready);
        case (it.command)
            sosfg_pkg::CMD_LOAD:  n_load++;
            sosfg_pkg::CMD_TICK:  n_tick++;
            sosfg_pkg::CMD_CLEAR: n_clear++;
            default:              n_unused++;
        endcase
    endtask

    // drop valid, wait for outstanding samples, let the core go idle
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [4:0] count_cfg, input logic [31:0] phase_cfg,
                             input int idle, input int stall, input int n_items);
        int sent;
        settle();
        write_reg(sosfg_pkg::REG_WAVE_COUNT, {27'd0, count_cfg});
        write_reg(sosfg_pkg::REG_INITIAL_PHASE, phase_cfg);
        n_settings++;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < n_items)
        begin
            sosfg_pkg::item_t it;
            it = random_item();
            send_item(it);
            if (it.command != CMD_UNUSED)
                sent++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every wave loaded before the first tick; extremes on the first four
        for (int w = 0; w < 16; w++)
        begin
            case (w)
                0:       send_item(load_item(w, 16'sh7FFF, -16'sh8000, 32'h0010_0000));
                1:       send_item(load_item(w, -16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF));
                2:       send_item(load_item(w, 16'sh0000, 16'sh0000, 32'h4000_0000));
                3:       send_item(load_item(w, -16'sh0001, 16'sh0001, 32'h8000_0000));
                default: send_item(load_item(w, random_weight(), random_weight(),
                                             random_step()));
            endcase
        end
        send_item(op_item(sosfg_pkg::CMD_TICK));
        send_item(op_item(CMD_UNUSED));
        send_item(op_item(sosfg_pkg::CMD_CLEAR));
        send_item(op_item(sosfg_pkg::CMD_TICK));
        // quarter-turn steps walk wave 0 through all four quadrant edges
        send_item(load_item(0, -16'sh8000, 16'sh7FFF, 32'h4000_0000));
        repeat (4) send_item(op_item(sosfg_pkg::CMD_TICK));

        run_phase(5'd16, 32'h0000_0000, 0, 0, 200);
        run_phase(5'd31, 32'hFFFF_FFFF, 63, 0, 150);
        run_phase(5'd0, 32'h8000_0000, 0, 63, 100);
        run_phase(5'($urandom_range(2, 15)), $urandom, 33, 33, 200);
        run_phase(5'd17, $urandom, 0, 0, 150);

        settle();
        $display("Sent %0d loads, %0d ticks, %0d clears, %0d unused commands; %0d checked",
                 n_load, n_tick, n_clear, n_unused, checked);
        $display("Covered %0d register settings (wave counts between 0 and 31, edge offsets)",
                 n_settings + 1);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
